/* src/hsv_to_rgb_convert_macros.svh */
// Assertion macros shared by the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERT_MACROS_SVH
`define HSV_TO_RGB_CONVERT_MACROS_SVH
`ifndef SYNTHESIS
`define HSVRGB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hsv_to_rgb_convert: assertion failed");
`define HSVRGB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hsv_to_rgb_convert: assertion failed");
`else
`define HSVRGB_ASSERT(label, clk, rst, prop)
`define HSVRGB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* src/hsvrgb_pkg.sv */
// Package with the types and constants of the HSV to RGB converter.
package hsvrgb_pkg;

  localparam logic [11:0] SECTOR_UNITS = 12'd3840;
  localparam logic [6:0]  SECTOR_HI    = 7'd15;
  localparam logic [7:0]  SECTOR_RECIP = 8'd137;
  localparam logic [7:0]  FULL_SCALE   = 8'd255;
  localparam logic [19:0] FRAC_DEN     = 20'd979200;
  localparam logic [16:0] P_RECIP      = 17'd65794;
  localparam logic [20:0] Q_RECIP      = 21'd1122868;

  typedef enum logic [3:0] {
    SECT_R_TO_Y = 4'd0,
    SECT_Y_TO_G = 4'd1,
    SECT_G_TO_C = 4'd2,
    SECT_C_TO_B = 4'd3,
    SECT_B_TO_M = 4'd4,
    SECT_M_TO_R = 4'd5
  } sector_t;

  typedef struct packed {
    logic       valid;
    logic       grey;
    logic [3:0] sector;
    logic [7:0] v;
  } hsvrgb_ctrl_t;

endpackage

/* src/hsvrgb_front.sv */
// Front stages: hue sector split and the narrow saturation products.
module hsvrgb_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [14:0]              hue,
  input  logic [7:0]               saturation,
  input  logic [7:0]               brightness,
  output hsvrgb_pkg::hsvrgb_ctrl_t ctrl,
  output logic [19:0]              sat_rem,
  output logic [19:0]              sat_rest,
  output logic [15:0]              p_prod
);

  hsvrgb_pkg::hsvrgb_ctrl_t c1;
  hsvrgb_pkg::hsvrgb_ctrl_t c1_next;
  logic [14:0] hue1;
  logic [7:0]  sat1;
  logic [14:0] sec_prod;
  logic [6:0]  base_hi;
  logic [14:0] rem_full;
  logic [11:0] rem;
  logic [11:0] rest;

  // The sector is hue / 3840, taken as (hue / 256) * 137 / 2048.
  assign sec_prod = 15'(hue[14:8]) * 15'(hsvrgb_pkg::SECTOR_RECIP);

  always_comb begin
    c1_next.valid  = start;
    c1_next.grey   = (saturation == 8'd0);
    c1_next.sector = sec_prod[14:11];
    c1_next.v      = brightness;
  end

  always_ff @(posedge clk) begin
    hue1 <= hue;
    sat1 <= saturation;
    if (rst) begin
      c1 <= '0;
    end else begin
      c1 <= c1_next;
    end
  end

  assign base_hi  = 7'(c1.sector) * hsvrgb_pkg::SECTOR_HI;
  assign rem_full = hue1 - {base_hi, 8'd0};
  assign rem      = rem_full[11:0];
  assign rest     = hsvrgb_pkg::SECTOR_UNITS - rem;

  always_ff @(posedge clk) begin
    sat_rem  <= 20'(sat1) * 20'(rem);
    sat_rest <= 20'(sat1) * 20'(rest);
    p_prod   <= 16'(c1.v) * 16'(hsvrgb_pkg::FULL_SCALE - sat1);
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl <= c1;
    end
  end

endmodule

/* src/hsvrgb_scale.sv */
// Scaling stages: brightness products and the exact constant divisions.
module hsvrgb_scale (
  input  logic                     clk,
  input  logic                     rst,
  input  hsvrgb_pkg::hsvrgb_ctrl_t ctrl_in,
  input  logic [19:0]              sat_rem,
  input  logic [19:0]              sat_rest,
  input  logic [15:0]              p_prod,
  output hsvrgb_pkg::hsvrgb_ctrl_t ctrl,
  output logic [7:0]               p,
  output logic [7:0]               q,
  output logic [7:0]               t
);

  hsvrgb_pkg::hsvrgb_ctrl_t c3;
  logic [19:0] dq;
  logic [19:0] dt;
  logic [32:0] p_mul;
  logic [27:0] num_q;
  logic [27:0] num_t;
  logic [7:0]  p3;
  logic [40:0] q_mul;
  logic [40:0] t_mul;

  assign dq    = hsvrgb_pkg::FRAC_DEN - sat_rem;
  assign dt    = hsvrgb_pkg::FRAC_DEN - sat_rest;
  // Division by 255 as a multiplication by the rounded-up reciprocal.
  assign p_mul = 33'(p_prod) * 33'(hsvrgb_pkg::P_RECIP);

  always_ff @(posedge clk) begin
    num_q <= 28'(ctrl_in.v) * 28'(dq);
    num_t <= 28'(ctrl_in.v) * 28'(dt);
    p3    <= p_mul[31:24];
    if (rst) begin
      c3 <= '0;
    end else begin
      c3 <= ctrl_in;
    end
  end

  // Division by 979200 is a shift by 8 and then a reciprocal product for 3825.
  assign q_mul = 41'(num_q[27:8]) * 41'(hsvrgb_pkg::Q_RECIP);
  assign t_mul = 41'(num_t[27:8]) * 41'(hsvrgb_pkg::Q_RECIP);

  always_ff @(posedge clk) begin
    p    <= p3;
    q    <= q_mul[39:32];
    t    <= t_mul[39:32];
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl <= c3;
    end
  end

endmodule

/* src/hsv_to_rgb_convert.sv */
// Top level of the HSV to RGB converter with the channel selection stage.
//
// A transaction is taken at each rising edge at which start is high and busy
// is low. Hue is in 1/64 degree, saturation and brightness are fractions of
// 255; the result is red, green and blue, each truncated to eight bits.
// busy is low at all times except during reset, so one transaction can be
// taken in every clock cycle.
// Each result appears on red, green and blue for exactly one cycle with done
// high, once its transaction has passed through the register stages below.
// Results leave in the order in which the transactions were taken.
// The work is spread over five register stages: sector split, narrow
// products, brightness products, constant division and channel selection.
// The receiver cannot hold results off, and none is needed: the pipeline
// never waits.
// Reset is synchronous; it empties the pipeline, so transactions in flight
// are dropped and done stays low until new ones arrive.
`include "hsv_to_rgb_convert_macros.svh"

module hsv_to_rgb_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  hsvrgb_pkg::hsvrgb_ctrl_t fr_ctrl;
  hsvrgb_pkg::hsvrgb_ctrl_t sc_ctrl;
  logic [19:0] sat_rem;
  logic [19:0] sat_rest;
  logic [15:0] p_prod;
  logic [7:0]  p;
  logic [7:0]  q;
  logic [7:0]  t;
  logic [7:0]  red_next;
  logic [7:0]  green_next;
  logic [7:0]  blue_next;

  assign busy = rst;

  hsvrgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .ctrl       (fr_ctrl),
    .sat_rem    (sat_rem),
    .sat_rest   (sat_rest),
    .p_prod     (p_prod)
  );

  hsvrgb_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (fr_ctrl),
    .sat_rem  (sat_rem),
    .sat_rest (sat_rest),
    .p_prod   (p_prod),
    .ctrl     (sc_ctrl),
    .p        (p),
    .q        (q),
    .t        (t)
  );

  always_comb begin
    red_next   = sc_ctrl.v;
    green_next = sc_ctrl.v;
    blue_next  = sc_ctrl.v;
    if (!sc_ctrl.grey) begin
      unique case (sc_ctrl.sector)
        hsvrgb_pkg::SECT_R_TO_Y: begin
          red_next = sc_ctrl.v; green_next = t;         blue_next = p;
        end
        hsvrgb_pkg::SECT_Y_TO_G: begin
          red_next = q;         green_next = sc_ctrl.v; blue_next = p;
        end
        hsvrgb_pkg::SECT_G_TO_C: begin
          red_next = p;         green_next = sc_ctrl.v; blue_next = t;
        end
        hsvrgb_pkg::SECT_C_TO_B: begin
          red_next = p;         green_next = q;         blue_next = sc_ctrl.v;
        end
        hsvrgb_pkg::SECT_B_TO_M: begin
          red_next = t;         green_next = p;         blue_next = sc_ctrl.v;
        end
        default: begin
          red_next = sc_ctrl.v; green_next = p;         blue_next = q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sc_ctrl.valid;
    end
  end

  `HSVRGB_ASSERT(a_latency, clk, rst, start && !busy |-> ##5 done)
  `HSVRGB_ASSERT(a_no_spurious, clk, rst, done |-> $past(start && !busy, 5))
  `HSVRGB_ASSERT(a_grey, clk, rst, sc_ctrl.valid && sc_ctrl.grey |=> red == green && green == blue)
  `HSVRGB_ASSERT(a_peak, clk, rst, sc_ctrl.valid |=> red == $past(sc_ctrl.v) || green == $past(sc_ctrl.v) || blue == $past(sc_ctrl.v))
  `HSVRGB_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !done)

endmodule

/* tb/sv/hsv_to_rgb_convert_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the HSV to RGB converter: directed, random and streaming colours.
module hsv_to_rgb_convert_tb;

  localparam int LATENCY = 5;
  localparam int MAX_HUE = 23039;
  localparam int TOP_HUE = 32767;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [14:0] hue = '0;
  logic [7:0]  saturation = '0;
  logic [7:0]  brightness = '0;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  rgb_t expected_colours[$];
  rgb_t oldest_colour;
  int   errors = 0;
  int   accepted = 0;
  int   checked = 0;
  int   greys = 0;
  int   past_last_sector = 0;

  hsv_to_rgb_convert dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic rgb_t convert_hsv(input logic [14:0] h, input logic [7:0] s,
                                       input logic [7:0] v);
    longint unsigned hh, ss, vv, sec, rem, p, q, t;
    rgb_t c;
    hh = h;
    ss = s;
    vv = v;
    if (ss == 0) begin
      c.red   = v;
      c.green = v;
      c.blue  = v;
      return c;
    end
    sec = hh / hsvrgb_pkg::SECTOR_UNITS;
    rem = hh % hsvrgb_pkg::SECTOR_UNITS;
    p = (vv * (hsvrgb_pkg::FULL_SCALE - ss)) / hsvrgb_pkg::FULL_SCALE;
    q = (vv * (hsvrgb_pkg::FRAC_DEN - ss * rem)) / hsvrgb_pkg::FRAC_DEN;
    t = (vv * (hsvrgb_pkg::FRAC_DEN - ss * (hsvrgb_pkg::SECTOR_UNITS - rem)))
        / hsvrgb_pkg::FRAC_DEN;
    case (sec)
      hsvrgb_pkg::SECT_R_TO_Y: begin c.red = v; c.green = t[7:0]; c.blue = p[7:0]; end
      hsvrgb_pkg::SECT_Y_TO_G: begin c.red = q[7:0]; c.green = v; c.blue = p[7:0]; end
      hsvrgb_pkg::SECT_G_TO_C: begin c.red = p[7:0]; c.green = v; c.blue = t[7:0]; end
      hsvrgb_pkg::SECT_C_TO_B: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v; end
      hsvrgb_pkg::SECT_B_TO_M: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v; end
      default:                 begin c.red = v; c.green = p[7:0]; c.blue = q[7:0]; end
    endcase
    return c;
  endfunction

  task automatic check_channel(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_colours.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                 $time, red, green, blue);
      end else begin
        oldest_colour = expected_colours.pop_front();
        check_channel("red", oldest_colour.red, red);
        check_channel("green", oldest_colour.green, green);
        check_channel("blue", oldest_colour.blue, blue);
        checked++;
      end
    end
    if (!rst && start && !busy) begin
      expected_colours.push_back(convert_hsv(hue, saturation, brightness));
      accepted++;
      if (saturation == 8'd0) greys++;
      if (hue > MAX_HUE) past_last_sector++;
    end
  end

  task automatic send_colour(input logic [14:0] h, input logic [7:0] s, input logic [7:0] v);
    @(negedge clk);
    start      <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start      <= 1'b0;
      hue        <= 15'($urandom);
      saturation <= 8'($urandom);
      brightness <= 8'($urandom);
    end
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < 25) idle_for($urandom_range(1, 2));
  endtask

  task automatic wait_for_results();
    idle_for(1);
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'd0;
    if (roll < 20) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [14:0] pick_hue();
    if ($urandom_range(99) < 10) return 15'($urandom_range(TOP_HUE, MAX_HUE + 1));
    return 15'($urandom_range(MAX_HUE));
  endfunction

  task automatic test_directed();
    send_colour(15'd0, 8'd255, 8'd255);
    send_colour(15'd1, 8'd255, 8'd255);
    send_colour(15'd3839, 8'd255, 8'd255);
    send_colour(15'd3840, 8'd255, 8'd255);
    send_colour(15'd7679, 8'd255, 8'd255);
    send_colour(15'd7680, 8'd255, 8'd255);
    send_colour(15'd11519, 8'd255, 8'd255);
    send_colour(15'd11520, 8'd255, 8'd255);
    send_colour(15'd15359, 8'd255, 8'd255);
    send_colour(15'd15360, 8'd255, 8'd255);
    send_colour(15'd19199, 8'd255, 8'd255);
    send_colour(15'd19200, 8'd255, 8'd255);
    send_colour(15'd23039, 8'd255, 8'd255);
    send_colour(15'd23040, 8'd255, 8'd255);
    send_colour(15'd32767, 8'd255, 8'd255);
    send_colour(15'd12345, 8'd0, 8'd200);
    send_colour(15'd0, 8'd0, 8'd0);
    send_colour(15'd23039, 8'd255, 8'd0);
    send_colour(15'd1920, 8'd1, 8'd255);
    send_colour(15'd5760, 8'd128, 8'd1);
    send_colour(15'd16384, 8'd200, 8'd137);
    send_colour(15'd10000, 8'd255, 8'd128);
    send_colour(15'd21000, 8'd85, 8'd170);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) begin
      maybe_idle();
      send_colour(pick_hue(), pick_level(), pick_level());
    end
  endtask

  task automatic test_streaming(input int count);
    repeat (count) send_colour(pick_hue(), pick_level(), pick_level());
  endtask

  task automatic test_pause_for_results(input int bursts, input int burst_len);
    repeat (bursts) begin
      repeat (burst_len) begin
        maybe_idle();
        send_colour(pick_hue(), pick_level(), pick_level());
      end
      wait_for_results();
    end
  endtask

  task automatic test_hue_beyond(input int count);
    repeat (count) begin
      maybe_idle();
      send_colour(15'($urandom_range(TOP_HUE, MAX_HUE + 1)), pick_level(), pick_level());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(700);
    test_streaming(300);
    test_pause_for_results(5, 20);
    test_hue_beyond(150);
    wait_for_results();

    $display("Run covered %0d transactions and %0d checked results: %0d grey, %0d with hue",
             accepted, checked, greys, past_last_sector);
    $display("past the last sector, with random gaps, a gap-free stream and drained bursts.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
